// ===== rtl/cons_heap_with_copying_gc_assert.svh =====
// ----------------------------------------------------------------------------
// cons heap assertion macros
// shared property forms for the cons heap checks
// ----------------------------------------------------------------------------
`ifndef CONS_HEAP_WITH_COPYING_GC_ASSERT_SVH
`define CONS_HEAP_WITH_COPYING_GC_ASSERT_SVH

// same-cycle implication
`define CHGC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHGC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/chgc_pkg.sv =====
// ----------------------------------------------------------------------------
// chgc_pkg
// types and codes shared by the cons heap controller and datapath
// ----------------------------------------------------------------------------
`default_nettype none
package chgc_pkg;
  localparam int TAG_W = 4;
  localparam int PAY_W = 32;
  localparam int VAL_W = 36;
  localparam int CFG_W = 11;
  localparam int ROOTS = 6;
  localparam int IN_W  = 96;
  localparam int OUT_W = 56;

  typedef logic [VAL_W-1:0] value_t;

  localparam logic [TAG_W-1:0] TAG_NULL   = 4'd0;
  localparam logic [TAG_W-1:0] TAG_PAIR   = 4'd1;
  localparam logic [TAG_W-1:0] TAG_BROKEN = 4'd2;

  typedef enum logic [3:0] {
    REQ_NEW     = 4'd0,
    REQ_CAR     = 4'd1,
    REQ_CDR     = 4'd2,
    REQ_SET_CAR = 4'd3,
    REQ_SET_CDR = 4'd4,
    REQ_ROOT_WR = 4'd5,
    REQ_ROOT_RD = 4'd6,
    REQ_PUSH    = 4'd7,
    REQ_POP     = 4'd8
  } req_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_OOM         = 3'd1,
    ST_BAD_PAIR    = 3'd2,
    ST_STACK_EMPTY = 3'd3,
    ST_STACK_FULL  = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_ACCEPT, OP_EXEC, OP_CAPTURE, OP_SRC_READ, OP_LOAD, OP_CHK,
    OP_RD, OP_FWD, OP_WB, OP_GC_END, OP_ALLOC, OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    TGT_ROOT, TGT_PEND, TGT_STACK, TGT_CAR, TGT_CDR
  } tgt_e;

  typedef struct packed {
    op_e  op;
    tgt_e tgt;
  } cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic need_gc;
    logic mem_read;
    logic trivial;
    logic broken;
    logic no_space;
    logic roots_last;
    logic pend_last;
    logic stack_done;
    logic scan_done;
    logic out_free;
  } sts_t;
endpackage
`default_nettype wire

// ===== rtl/chgc_ram.sv =====
// ----------------------------------------------------------------------------
// chgc_ram
// single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module chgc_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 64
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire [WIDTH-1:0]          wdata_i,
  input  wire                      re_i,
  input  wire [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/chgc_ctrl.sv =====
// ----------------------------------------------------------------------------
// chgc_ctrl
// request sequencer and cheney copy walker for the cons heap
// ----------------------------------------------------------------------------
`default_nettype none
module chgc_ctrl
  import chgc_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   in_valid_i,
  output logic  in_ready_o,
  input  sts_t  sts_i,
  output cmd_t  cmd_o
);
  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_EXEC  = 12'b000000000010,
    S_CAPT  = 12'b000000000100,
    S_LOAD  = 12'b000000001000,
    S_LATCH = 12'b000000010000,
    S_CHK   = 12'b000000100000,
    S_RD    = 12'b000001000000,
    S_FWD   = 12'b000010000000,
    S_WB    = 12'b000100000000,
    S_END   = 12'b001000000000,
    S_ALLOC = 12'b010000000000,
    S_EMIT  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  tgt_e   tgt_q, tgt_d;

  always_comb begin
    state_d    = state_q;
    tgt_d      = tgt_q;
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    cmd_o.tgt  = tgt_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.op = OP_EXEC;
        if (sts_i.is_alloc && sts_i.need_gc) begin
          tgt_d   = TGT_ROOT;
          state_d = S_LOAD;
        end else if (sts_i.mem_read) begin
          state_d = S_CAPT;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_CAPT: begin
        cmd_o.op = OP_CAPTURE;
        state_d  = S_EMIT;
      end
      S_LOAD: begin
        case (tgt_q)
          TGT_STACK: begin
            if (sts_i.stack_done) begin
              tgt_d = TGT_CAR;
            end else begin
              cmd_o.op = OP_SRC_READ;
              state_d  = S_LATCH;
            end
          end
          TGT_CAR: begin
            if (sts_i.scan_done) begin
              state_d = S_END;
            end else begin
              cmd_o.op = OP_SRC_READ;
              state_d  = S_LATCH;
            end
          end
          default: state_d = S_LATCH;
        endcase
      end
      S_LATCH: begin
        cmd_o.op = OP_LOAD;
        state_d  = S_CHK;
      end
      S_CHK: begin
        cmd_o.op = OP_CHK;
        state_d  = sts_i.trivial ? S_WB : S_RD;
      end
      S_RD: begin
        cmd_o.op = OP_RD;
        state_d  = (sts_i.broken || sts_i.no_space) ? S_WB : S_FWD;
      end
      S_FWD: begin
        cmd_o.op = OP_FWD;
        state_d  = S_WB;
      end
      S_WB: begin
        cmd_o.op = OP_WB;
        state_d  = S_LOAD;
        case (tgt_q)
          TGT_ROOT:  if (sts_i.roots_last) tgt_d = TGT_PEND;
          TGT_PEND:  if (sts_i.pend_last) tgt_d = TGT_STACK;
          TGT_CAR: begin
            tgt_d   = TGT_CDR;
            state_d = S_LATCH;
          end
          TGT_CDR:   tgt_d = TGT_CAR;
          default:   ;
        endcase
      end
      S_END: begin
        cmd_o.op = OP_GC_END;
        state_d  = S_ALLOC;
      end
      S_ALLOC: begin
        cmd_o.op = OP_ALLOC;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tgt_q   <= TGT_ROOT;
    end else begin
      state_q <= state_d;
      tgt_q   <= tgt_d;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/chgc_dp.sv =====
// ----------------------------------------------------------------------------
// chgc_dp
// heap semispaces, roots, stack and copy registers of the cons heap
// ----------------------------------------------------------------------------
`default_nettype none
module chgc_dp
  import chgc_pkg::*;
#(
  parameter int PAIRS       = 1024,
  parameter int STACK_DEPTH = 64
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  wire [IN_W-1:0]    in_data_i,
  input  wire               cfg_we_i,
  input  wire [CFG_W-1:0]   cfg_wdata_i,
  input  wire               out_ready_i,
  output logic              out_valid_o,
  output logic [OUT_W-1:0]  out_data_o
);
  localparam int AW   = $clog2(PAIRS);
  localparam int CNTW = $clog2(PAIRS + 1);
  localparam int SAW  = $clog2(STACK_DEPTH);
  localparam int SLW  = $clog2(STACK_DEPTH + 1);

  // request
  logic [3:0]       req_q;
  logic [9:0]       idx_in_q;
  logic [2:0]       root_q;
  value_t           a_q, b_q;
  // heap state
  logic             half_q;
  logic [CNTW-1:0]  alloc_q, cf_q, scan_q;
  logic [CFG_W-1:0] heap_size_q;
  value_t           roots_q [ROOTS];
  value_t           pend_q [2];
  logic [SLW-1:0]   level_q, idx_q;
  // copy walk and result
  value_t           mig_q, scdr_q, res_q;
  status_e          st_q;
  logic             ran_q;

  logic [CNTW-1:0]  size;
  logic             need_gc, bad_ref, stk_full, stk_empty, root_ok;
  logic [AW-1:0]    ptr;
  value_t           car_rdata, cdr_rdata, stk_rdata;
  logic             car_we, cdr_we, car_re, cdr_re, stk_we, stk_re;
  logic [AW:0]      car_waddr, cdr_waddr, heap_raddr;
  value_t           car_wdata, cdr_wdata, stk_wdata;
  logic [SAW-1:0]   stk_waddr, stk_raddr;
  logic [CFG_W-1:0] free_cells;

  assign size      = (32'(heap_size_q) > PAIRS) ? CNTW'(PAIRS) : CNTW'(heap_size_q);
  assign need_gc   = alloc_q >= size;
  assign bad_ref   = 32'(idx_in_q) >= 32'(alloc_q);
  assign stk_full  = level_q >= SLW'(STACK_DEPTH);
  assign stk_empty = level_q == '0;
  assign root_ok   = root_q < 3'(ROOTS);
  assign ptr       = AW'(mig_q[PAY_W-1:0]);
  assign free_cells = need_gc ? '0 : CFG_W'(size - alloc_q);

  assign sts_o.is_alloc   = req_q == REQ_NEW;
  assign sts_o.need_gc    = need_gc;
  assign sts_o.mem_read   = ((req_q == REQ_CAR || req_q == REQ_CDR) && !bad_ref) ||
                            (req_q == REQ_POP && !stk_empty);
  // only pair values pointing below the old fill level need moving
  assign sts_o.trivial    = (mig_q[VAL_W-1:PAY_W] != TAG_PAIR) ||
                            (mig_q[PAY_W-1:0] >= 32'(alloc_q));
  assign sts_o.broken     = car_rdata[VAL_W-1:PAY_W] == TAG_BROKEN;
  assign sts_o.no_space   = cf_q >= size;
  assign sts_o.roots_last = idx_q == SLW'(ROOTS - 1);
  assign sts_o.pend_last  = idx_q == SLW'(1);
  assign sts_o.stack_done = idx_q >= level_q;
  assign sts_o.scan_done  = scan_q >= cf_q;
  assign sts_o.out_free   = !out_valid_o || out_ready_i;

  always_comb begin
    car_we     = 1'b0;
    cdr_we     = 1'b0;
    car_re     = 1'b0;
    cdr_re     = 1'b0;
    stk_we     = 1'b0;
    stk_re     = 1'b0;
    car_waddr  = {half_q, AW'(alloc_q)};
    cdr_waddr  = {half_q, AW'(alloc_q)};
    car_wdata  = a_q;
    cdr_wdata  = b_q;
    heap_raddr = {half_q, AW'(idx_in_q)};
    stk_waddr  = SAW'(level_q);
    stk_wdata  = a_q;
    stk_raddr  = SAW'(level_q - SLW'(1));
    case (cmd_i.op)
      OP_EXEC: begin
        case (req_q)
          REQ_NEW: begin
            car_we = !need_gc;
            cdr_we = !need_gc;
          end
          REQ_CAR, REQ_CDR: begin
            car_re = !bad_ref;
            cdr_re = !bad_ref;
          end
          REQ_SET_CAR: begin
            car_we    = !bad_ref;
            car_waddr = {half_q, AW'(idx_in_q)};
          end
          REQ_SET_CDR: begin
            cdr_we    = !bad_ref;
            cdr_waddr = {half_q, AW'(idx_in_q)};
            cdr_wdata = a_q;
          end
          REQ_PUSH: stk_we = !stk_full;
          REQ_POP:  stk_re = !stk_empty;
          default:  ;
        endcase
      end
      OP_SRC_READ: begin
        if (cmd_i.tgt == TGT_STACK) begin
          stk_re    = 1'b1;
          stk_raddr = SAW'(idx_q);
        end else begin
          car_re     = 1'b1;
          cdr_re     = 1'b1;
          heap_raddr = {~half_q, AW'(scan_q)};
        end
      end
      OP_CHK: begin
        car_re     = !sts_o.trivial;
        cdr_re     = !sts_o.trivial;
        heap_raddr = {half_q, ptr};
      end
      OP_RD: begin
        car_we    = !sts_o.broken && !sts_o.no_space;
        cdr_we    = !sts_o.broken && !sts_o.no_space;
        car_waddr = {~half_q, AW'(cf_q)};
        cdr_waddr = {~half_q, AW'(cf_q)};
        car_wdata = car_rdata;
        cdr_wdata = cdr_rdata;
      end
      OP_FWD: begin
        // leave a broken heart and the forwarding pair behind
        car_we    = 1'b1;
        cdr_we    = 1'b1;
        car_waddr = {half_q, ptr};
        cdr_waddr = {half_q, ptr};
        car_wdata = {TAG_BROKEN, 32'd0};
        cdr_wdata = {TAG_PAIR, 32'(cf_q)};
      end
      OP_WB: begin
        car_waddr = {~half_q, AW'(scan_q)};
        cdr_waddr = {~half_q, AW'(scan_q)};
        car_wdata = mig_q;
        cdr_wdata = mig_q;
        stk_waddr = SAW'(idx_q);
        stk_wdata = mig_q;
        case (cmd_i.tgt)
          TGT_STACK: stk_we = 1'b1;
          TGT_CAR:   car_we = 1'b1;
          TGT_CDR:   cdr_we = 1'b1;
          default:   ;
        endcase
      end
      OP_ALLOC: begin
        car_we    = !need_gc;
        cdr_we    = !need_gc;
        car_wdata = pend_q[0];
        cdr_wdata = pend_q[1];
      end
      default: ;
    endcase
  end

  chgc_ram #(.WIDTH(VAL_W), .DEPTH(2 * PAIRS)) u_car_ram (
    .clk_i   (clk_i),
    .we_i    (car_we),
    .waddr_i (car_waddr),
    .wdata_i (car_wdata),
    .re_i    (car_re),
    .raddr_i (heap_raddr),
    .rdata_o (car_rdata)
  );

  chgc_ram #(.WIDTH(VAL_W), .DEPTH(2 * PAIRS)) u_cdr_ram (
    .clk_i   (clk_i),
    .we_i    (cdr_we),
    .waddr_i (cdr_waddr),
    .wdata_i (cdr_wdata),
    .re_i    (cdr_re),
    .raddr_i (heap_raddr),
    .rdata_o (cdr_rdata)
  );

  chgc_ram #(.WIDTH(VAL_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // control state and architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q      <= 1'b0;
      alloc_q     <= '0;
      cf_q        <= '0;
      scan_q      <= '0;
      level_q     <= '0;
      idx_q       <= '0;
      heap_size_q <= CFG_W'(1024);
      out_valid_o <= 1'b0;
      for (int i = 0; i < ROOTS; i++) roots_q[i] <= '0;
      pend_q[0]   <= '0;
      pend_q[1]   <= '0;
    end else begin
      if (cfg_we_i) heap_size_q <= cfg_wdata_i;
      if (cmd_i.op == OP_EMIT) out_valid_o <= 1'b1;
      else if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      case (cmd_i.op)
        OP_EXEC: begin
          case (req_q)
            REQ_NEW: begin
              if (need_gc) begin
                pend_q[0] <= a_q;
                pend_q[1] <= b_q;
                cf_q      <= '0;
                scan_q    <= '0;
                idx_q     <= '0;
              end else begin
                alloc_q <= alloc_q + CNTW'(1);
              end
            end
            REQ_ROOT_WR: if (root_ok) roots_q[root_q] <= a_q;
            REQ_PUSH:    if (!stk_full) level_q <= level_q + SLW'(1);
            REQ_POP:     if (!stk_empty) level_q <= level_q - SLW'(1);
            default:     ;
          endcase
        end
        OP_FWD: cf_q <= cf_q + CNTW'(1);
        OP_WB: begin
          case (cmd_i.tgt)
            TGT_ROOT: begin
              roots_q[idx_q[2:0]] <= mig_q;
              idx_q <= sts_o.roots_last ? '0 : idx_q + SLW'(1);
            end
            TGT_PEND: begin
              pend_q[idx_q[0]] <= mig_q;
              idx_q <= sts_o.pend_last ? '0 : idx_q + SLW'(1);
            end
            TGT_STACK: idx_q <= idx_q + SLW'(1);
            TGT_CDR:   scan_q <= scan_q + CNTW'(1);
            default:   ;
          endcase
        end
        OP_GC_END: begin
          half_q  <= ~half_q;
          alloc_q <= cf_q;
        end
        OP_ALLOC: begin
          if (!need_gc) alloc_q <= alloc_q + CNTW'(1);
          pend_q[0] <= '0;
          pend_q[1] <= '0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_ACCEPT: begin
        req_q    <= in_data_i[3:0];
        idx_in_q <= in_data_i[13:4];
        root_q   <= in_data_i[16:14];
        a_q      <= {in_data_i[20:17], in_data_i[52:21]};
        b_q      <= {in_data_i[56:53], in_data_i[88:57]};
        res_q    <= '0;
        st_q     <= ST_OK;
        ran_q    <= 1'b0;
      end
      OP_EXEC: begin
        case (req_q)
          REQ_NEW: begin
            if (need_gc) ran_q <= 1'b1;
            else res_q <= {TAG_PAIR, 32'(alloc_q)};
          end
          REQ_CAR, REQ_CDR, REQ_SET_CAR, REQ_SET_CDR: if (bad_ref) st_q <= ST_BAD_PAIR;
          REQ_ROOT_RD: if (root_ok) res_q <= roots_q[root_q];
          REQ_PUSH:    if (stk_full) st_q <= ST_STACK_FULL;
          REQ_POP:     if (stk_empty) st_q <= ST_STACK_EMPTY;
          default:     ;
        endcase
      end
      OP_CAPTURE: begin
        if (req_q == REQ_POP)      res_q <= stk_rdata;
        else if (req_q == REQ_CAR) res_q <= car_rdata;
        else                       res_q <= cdr_rdata;
      end
      OP_LOAD: begin
        case (cmd_i.tgt)
          TGT_ROOT:  mig_q <= roots_q[idx_q[2:0]];
          TGT_PEND:  mig_q <= pend_q[idx_q[0]];
          TGT_STACK: mig_q <= stk_rdata;
          TGT_CAR: begin
            mig_q  <= car_rdata;
            scdr_q <= cdr_rdata;
          end
          default:   mig_q <= scdr_q;
        endcase
      end
      OP_RD:  if (sts_o.broken) mig_q <= cdr_rdata;
      OP_FWD: mig_q <= {TAG_PAIR, 32'(cf_q)};
      OP_ALLOC: begin
        if (need_gc) begin
          st_q  <= ST_OOM;
          res_q <= '0;
        end else begin
          res_q <= {TAG_PAIR, 32'(alloc_q)};
        end
      end
      OP_EMIT: out_data_o <= {5'd0, ran_q, free_cells, st_q, res_q[PAY_W-1:0],
                              res_q[VAL_W-1:PAY_W]};
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/cons_heap_with_copying_gc.sv =====
// ----------------------------------------------------------------------------
// cons_heap_with_copying_gc
// pair heap in two semispaces with roots, root stack and a cheney collector
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_axis    in   tvalid / tready      request word (96 bits)
//  m_axis    out  tvalid / tready      response word (56 bits)
//  cfg       in   cfg_we_i             heap_size (11 bits)
//
//  a response word is registered after its request word is taken; car, cdr and
//  pop with a valid cell or stack entry first take one registered read of a heap
//  or stack ram. the next request word is taken only once the response is emitted.
//  an allocation into a full heap first runs a collection over every root,
//  pending value and stack entry, then over every copied cell; each heap ram has
//  a single write port. intake stalls meanwhile.
//  reset clears roots, stack level and fill level; no clearing pass is needed.
//  a held response does not block intake; the next one waits for it.
// ----------------------------------------------------------------------------
`default_nettype none
module cons_heap_with_copying_gc
  import chgc_pkg::*;
#(
  parameter int PAIRS       = 1024,
  parameter int STACK_DEPTH = 64
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               s_axis_tvalid,
  output logic              s_axis_tready,
  // req_type, cell_index, root_index, a_tag, a_payload, b_tag, b_payload
  input  wire [IN_W-1:0]    s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire               m_axis_tready,
  // out_tag, out_payload, status, free_cells, collected
  output logic [OUT_W-1:0]  m_axis_tdata,
  input  wire               cfg_we_i,
  input  wire [CFG_W-1:0]   cfg_wdata_i
);
  cmd_t cmd;
  sts_t sts;
  logic [2:0]  rsp_st;
  logic        rsp_gc;
  value_t      rsp_val;

  chgc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  chgc_dp #(.PAIRS(PAIRS), .STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

  assign rsp_st  = m_axis_tdata[38:36];
  assign rsp_gc  = m_axis_tdata[50];
  assign rsp_val = m_axis_tdata[35:0];

`include "cons_heap_with_copying_gc_assert.svh"

  `CHGC_ASSERT_IMP(a_oom_collected, m_axis_tvalid && rsp_st == ST_OOM, rsp_gc, "oom without gc")
  `CHGC_ASSERT_IMP(a_empty_null, m_axis_tvalid && rsp_st == ST_STACK_EMPTY, rsp_val == '0, "empty pop")
  `CHGC_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "busy")
endmodule
`default_nettype wire
